FILE: rtl/core/tftpsc_pkg.sv
// Package: shared types and constants for the TFTP session controller.
`default_nettype none
package tftpsc_pkg;
    localparam int unsigned MaxPayload = 512;
    localparam logic [9:0] HdrLen = 10'd4;
    localparam logic [9:0] ErrLen = 10'd5;
    localparam logic [9:0] FullLen = 10'(MaxPayload + 4);

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_ACK = 3'd1;
    localparam logic [2:0] KIND_DATA = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_RESEND = 3'd4;

    localparam logic [2:0] FS_NONE = 3'd0;
    localparam logic [2:0] FS_OPEN_READ = 3'd1;
    localparam logic [2:0] FS_OPEN_WRITE = 3'd2;
    localparam logic [2:0] FS_READ = 3'd3;
    localparam logic [2:0] FS_WRITE = 3'd4;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_NOT_FOUND = 3'd1;
    localparam logic [2:0] ERR_ACCESS = 3'd2;
    localparam logic [2:0] ERR_ILLEGAL = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN_TID = 3'd5;

    localparam logic [15:0] OP_RRQ = 16'd1;
    localparam logic [15:0] OP_WRQ = 16'd2;
    localparam logic [15:0] OP_DATA = 16'd3;
    localparam logic [15:0] OP_ACK = 16'd4;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRY = 1'b1;

    typedef enum logic [2:0] {
        CLS_TICK, CLS_RRQ, CLS_WRQ, CLS_DATA, CLS_ACK, CLS_ILLEGAL
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [15:0] block_in;
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
        logic        short_pkt;
        logic        open_ok;
        logic        read_err;
        logic [9:0]  data_len;
        logic        write_ok;
    } item_t;

    typedef struct packed {
        logic [2:0]  send_kind;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic [15:0] block_out;
        logic [2:0]  error_code;
        logic [9:0]  send_len;
        logic [2:0]  fs_request;
        logic        close_file;
    } cmd_t;
endpackage
`default_nettype wire

FILE: rtl/core/tftp_server_session_control_core.sv
// Top level: TFTP server session controller with config registers.
// One transaction per cycle unless out_ready stalls: a classifying
// front end feeds a two-entry queue, and the session update loads the
// command register after the queue slot that held the item. Config
// registers reset to timeout 5000 ms and retry limit 5.
`default_nettype none
module tftp_server_session_control_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic [15:0]        opcode,
    input  wire logic [15:0]        block_in,
    input  wire logic [31:0]        remote_addr,
    input  wire logic [15:0]        remote_port,
    input  wire logic [9:0]         packet_len,
    input  wire logic               open_ok,
    input  wire logic signed [10:0] read_len,
    input  wire logic               write_ok,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              send_kind,
    output logic [31:0]             dest_addr,
    output logic [15:0]             dest_port,
    output logic [15:0]             block_out,
    output logic [2:0]              error_code,
    output logic [9:0]              send_len,
    output logic [2:0]              fs_request,
    output logic                    close_file
);
    import tftpsc_pkg::*;

    logic [15:0] timeout_reg;
    logic [7:0]  retry_lim_reg;
    logic        q_valid, q_ready, active;
    item_t       q_item;
    cmd_t        cmd;

    assign cfg_ready = 1'b1;

    // Write config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= 16'd5000;
            retry_lim_reg <= 8'd5;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_TIMEOUT)
                timeout_reg <= cfg_data;
            else
                retry_lim_reg <= cfg_data[7:0];
        end
    end

    tftpsc_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .action, .opcode, .block_in,
        .remote_addr, .remote_port, .packet_len, .open_ok, .read_len,
        .write_ok, .q_valid, .q_ready, .q_item
    );

    tftpsc_back u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_item,
        .timeout_ms(timeout_reg), .retry_limit(retry_lim_reg),
        .out_valid, .out_ready, .cmd, .active
    );

    assign send_kind  = cmd.send_kind;
    assign dest_addr  = cmd.dest_addr;
    assign dest_port  = cmd.dest_port;
    assign block_out  = cmd.block_out;
    assign error_code = cmd.error_code;
    assign send_len   = cmd.send_len;
    assign fs_request = cmd.fs_request;
    assign close_file = cmd.close_file;

`ifndef ASSERT_OFF
    a_close_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && u_back.cmd_next.close_file) |=> !active)
        else $error("close without session drop");
    a_resend_peer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && send_kind == KIND_RESEND) |-> block_out == 16'd0)
        else $error("resend with block number");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/tftpsc_front.sv
// Front end: accepts input transactions, classifies them and queues them.
`default_nettype none
module tftpsc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                action,
    input  wire logic [15:0]         opcode,
    input  wire logic [15:0]         block_in,
    input  wire logic [31:0]         remote_addr,
    input  wire logic [15:0]         remote_port,
    input  wire logic [9:0]          packet_len,
    input  wire logic                open_ok,
    input  wire logic signed [10:0]  read_len,
    input  wire logic                write_ok,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output tftpsc_pkg::item_t        q_item
);
    import tftpsc_pkg::*;

    item_t       slot_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, rd_ptr_reg;
    item_t       cls_item;
    logic        push, pop;

    // Classify the incoming transaction
    always_comb
    begin
        cls_item.block_in    = block_in;
        cls_item.remote_addr = remote_addr;
        cls_item.remote_port = remote_port;
        cls_item.short_pkt   = packet_len < FullLen;
        cls_item.open_ok     = open_ok;
        cls_item.read_err    = read_len[10];
        cls_item.data_len    = (read_len > 11'sd512) ? 10'(MaxPayload) + HdrLen
                                                    : read_len[9:0] + HdrLen;
        cls_item.write_ok    = write_ok;
        if (action)
            cls_item.cls = CLS_TICK;
        else if (opcode == OP_RRQ)
            cls_item.cls = CLS_RRQ;
        else if (opcode == OP_WRQ)
            cls_item.cls = CLS_WRQ;
        else if (opcode == OP_DATA)
            cls_item.cls = CLS_DATA;
        else if (opcode == OP_ACK)
            cls_item.cls = CLS_ACK;
        else
            cls_item.cls = CLS_ILLEGAL;
    end

    assign in_ready = count_reg != 2'd2;
    assign q_valid  = count_reg != 2'd0;
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    // Hold queued payload
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls_item;
    end
endmodule
`default_nettype wire

FILE: rtl/core/tftpsc_back.sv
// Back end: session state update and command register.
`default_nettype none
module tftpsc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire tftpsc_pkg::item_t  q_item,
    input  wire logic [15:0]        timeout_ms,
    input  wire logic [7:0]         retry_limit,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tftpsc_pkg::cmd_t        cmd,
    output logic                    active
);
    import tftpsc_pkg::*;

    logic        active_reg, active_next;
    logic        wmode_reg, wmode_next;
    logic [15:0] blk_reg, blk_next;
    logic [9:0]  last_reg, last_next;
    logic [7:0]  retry_reg, retry_next;
    logic [15:0] idle_reg, idle_next;
    logic [31:0] paddr_reg, paddr_next;
    logic [15:0] pport_reg, pport_next;
    logic        ovalid_reg;
    cmd_t        cmd_reg, cmd_next;
    logic        fire;

    assign q_ready   = !ovalid_reg || out_ready;
    assign fire      = q_valid && q_ready;
    assign out_valid = ovalid_reg;
    assign cmd       = cmd_reg;
    assign active    = active_reg;

    // Compute next session state and command
    always_comb
    begin
        active_next = active_reg;
        wmode_next  = wmode_reg;
        blk_next    = blk_reg;
        last_next   = last_reg;
        retry_next  = retry_reg;
        idle_next   = idle_reg;
        paddr_next  = paddr_reg;
        pport_next  = pport_reg;
        cmd_next    = '0;
        case (q_item.cls)
            CLS_TICK:
            begin
                if (active_reg)
                begin
                    if (idle_reg >= timeout_ms)
                    begin
                        idle_next = 16'd0;
                        if (retry_reg != 8'hFF)
                            retry_next = retry_reg + 8'd1;
                        cmd_next.send_kind = KIND_RESEND;
                        cmd_next.dest_addr = paddr_reg;
                        cmd_next.dest_port = pport_reg;
                        cmd_next.send_len  = last_reg;
                        if (retry_next > retry_limit)
                        begin
                            cmd_next.close_file = 1'b1;
                            active_next = 1'b0;
                        end
                    end
                    else if (idle_reg != 16'hFFFF)
                        idle_next = idle_reg + 16'd1;
                end
            end
            CLS_RRQ, CLS_WRQ:
            begin
                cmd_next.send_kind  = KIND_ERROR;
                cmd_next.dest_addr  = q_item.remote_addr;
                cmd_next.dest_port  = q_item.remote_port;
                cmd_next.send_len   = ErrLen;
                if (active_reg)
                    cmd_next.error_code = ERR_ACCESS;
                else
                begin
                    cmd_next.fs_request = (q_item.cls == CLS_RRQ) ? FS_OPEN_READ
                                                                  : FS_OPEN_WRITE;
                    blk_next = 16'd1;
                    if (!q_item.open_ok)
                        cmd_next.error_code = ERR_NOT_FOUND;
                    else
                    begin
                        active_next = 1'b1;
                        paddr_next  = q_item.remote_addr;
                        pport_next  = q_item.remote_port;
                        idle_next   = 16'd0;
                        retry_next  = 8'd0;
                        cmd_next.dest_addr = q_item.remote_addr;
                        cmd_next.dest_port = q_item.remote_port;
                        if (q_item.cls == CLS_WRQ)
                        begin
                            wmode_next = 1'b1;
                            last_next  = HdrLen;
                            cmd_next.send_kind = KIND_ACK;
                            cmd_next.send_len  = HdrLen;
                        end
                        else
                        begin
                            wmode_next = 1'b0;
                            last_next  = 10'd0;
                            if (q_item.read_err)
                            begin
                                cmd_next.error_code = ERR_ACCESS;
                                cmd_next.close_file = 1'b1;
                                active_next = 1'b0;
                            end
                            else
                            begin
                                last_next = q_item.data_len;
                                cmd_next.send_kind = KIND_DATA;
                                cmd_next.block_out = 16'd1;
                                cmd_next.send_len  = q_item.data_len;
                            end
                        end
                    end
                end
            end
            CLS_ACK:
            begin
                cmd_next.send_kind = KIND_ERROR;
                cmd_next.dest_addr = q_item.remote_addr;
                cmd_next.dest_port = q_item.remote_port;
                cmd_next.send_len  = ErrLen;
                if (!active_reg || wmode_reg)
                    cmd_next.error_code = ERR_ACCESS;
                else if (q_item.block_in != blk_reg)
                    cmd_next.error_code = ERR_UNKNOWN_TID;
                else if (last_reg == 10'd0 || last_reg == FullLen)
                begin
                    blk_next = blk_reg + 16'd1;
                    cmd_next.fs_request = FS_READ;
                    cmd_next.dest_addr  = paddr_reg;
                    cmd_next.dest_port  = pport_reg;
                    if (q_item.read_err)
                    begin
                        cmd_next.error_code = ERR_ACCESS;
                        cmd_next.close_file = 1'b1;
                        active_next = 1'b0;
                    end
                    else
                    begin
                        last_next = q_item.data_len;
                        idle_next = 16'd0;
                        cmd_next.send_kind = KIND_DATA;
                        cmd_next.block_out = blk_next;
                        cmd_next.send_len  = q_item.data_len;
                    end
                end
                else
                begin
                    cmd_next = '0;
                    cmd_next.close_file = 1'b1;
                    active_next = 1'b0;
                end
            end
            CLS_DATA:
            begin
                cmd_next.send_kind = KIND_ERROR;
                cmd_next.dest_addr = q_item.remote_addr;
                cmd_next.dest_port = q_item.remote_port;
                cmd_next.send_len  = ErrLen;
                if (!active_reg || !wmode_reg)
                    cmd_next.error_code = ERR_ACCESS;
                else
                begin
                    cmd_next.fs_request = FS_WRITE;
                    if (!q_item.write_ok)
                    begin
                        cmd_next.error_code = ERR_ACCESS;
                        cmd_next.close_file = 1'b1;
                        active_next = 1'b0;
                    end
                    else
                    begin
                        last_next = HdrLen;
                        idle_next = 16'd0;
                        cmd_next.send_kind = KIND_ACK;
                        cmd_next.dest_addr = paddr_reg;
                        cmd_next.dest_port = pport_reg;
                        cmd_next.block_out = q_item.block_in;
                        cmd_next.send_len  = HdrLen;
                        if (q_item.short_pkt)
                        begin
                            cmd_next.close_file = 1'b1;
                            active_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                cmd_next.send_kind  = KIND_ERROR;
                cmd_next.dest_addr  = q_item.remote_addr;
                cmd_next.dest_port  = q_item.remote_port;
                cmd_next.send_len   = ErrLen;
                cmd_next.error_code = ERR_ILLEGAL;
            end
        endcase
    end

    // Advance session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            wmode_reg  <= 1'b0;
            blk_reg    <= 16'd0;
            last_reg   <= 10'd0;
            retry_reg  <= 8'd0;
            idle_reg   <= 16'd0;
            paddr_reg  <= 32'd0;
            pport_reg  <= 16'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                active_reg <= active_next;
                wmode_reg  <= wmode_next;
                blk_reg    <= blk_next;
                last_reg   <= last_next;
                retry_reg  <= retry_next;
                idle_reg   <= idle_next;
                paddr_reg  <= paddr_next;
                pport_reg  <= pport_next;
            end
            if (q_ready)
                ovalid_reg <= fire;
        end
    end

    // Hold command payload
    always_ff @(posedge clk)
    begin
        if (fire)
            cmd_reg <= cmd_next;
    end
endmodule
`default_nettype wire
